FILE: rtl/hsl_pkg.sv
package hsl_pkg;

	localparam int FRAC_BITS = 24;
	localparam int UNIT_BITS = FRAC_BITS + 1;
	localparam int NUM_CH = 3;
	localparam int CH_RED = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE = 2;

	localparam logic [8:0] HUE_MAX = 9'd360;
	localparam logic [7:0] SCALE_MAX = 8'd200;
	localparam logic [7:0] LIT_HALF = 8'd100;

	// The scale from 0..200 to 24 fraction bits is a reciprocal multiply that is
	// exact over the whole input range: ceil(2^40 / 200), shifted by 40 - 24.
	localparam logic [32:0] UNIT_RECIP = 33'd5497558139;
	localparam int UNIT_SHIFT = 16;

	// Grey level is (lightness * 510 + 200) / 400, again an exact reciprocal.
	localparam logic [17:0] GRAY_RECIP = 18'd167773;
	localparam int GRAY_SHIFT = 26;

	localparam logic [UNIT_BITS-1:0] UNIT_ONE = UNIT_BITS'(1) << FRAC_BITS;

	typedef logic [UNIT_BITS-1:0] unit_t;
	typedef logic [5:0] weight_t;
	typedef logic [29:0] num_t;

	typedef struct packed {
		unit_t s;
		unit_t l;
		logic lit_lo;
		logic sat_zero;
		logic [7:0] gray;
		weight_t [NUM_CH-1:0] w;
	} norm_t;

	typedef struct packed {
		unit_t v1;
		unit_t span;
		logic sat_zero;
		logic [7:0] gray;
		weight_t [NUM_CH-1:0] w;
	} light_t;

	// Weight of the span in sixtieths for a wrapped angle in degrees.
	function automatic weight_t ramp_weight(input logic [8:0] d);
		logic [8:0] fall;
		fall = 9'd240 - d;
		if (d < 9'd60) begin
			return d[5:0];
		end else if (d < 9'd180) begin
			return 6'd60;
		end else if (d < 9'd240) begin
			return fall[5:0];
		end else begin
			return 6'd0;
		end
	endfunction

endpackage

FILE: rtl/hsl_if.sv
interface hsl_in_if;
	logic valid;
	logic ready;
	logic [8:0] hue;
	logic [7:0] saturation;
	logic [7:0] lightness;

	modport source(output valid, hue, saturation, lightness, input ready);
	modport sink(input valid, hue, saturation, lightness, output ready);
endinterface

interface hsl_out_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

FILE: rtl/hsl_to_rgb_pixel.sv
// HSL to RGB pixel converter.
// Items enter on the hsl channel (hue 0..360 degrees, saturation and lightness
// on a 0..200 scale; larger codes are saturated) and leave on the rgb channel
// as three 8-bit channel bytes, one result item for each input item, in order.
// Both channels use valid/ready; an item moves when both are high at a clock edge.
// The datapath is a six stage pipeline: scaling and hue weights, the
// saturation-lightness product, the upper ramp level, the lower level and
// span, the per-channel ramp products, and the final byte rounding.
// Throughput is one item per cycle while the rgb receiver is ready, with each
// stage holding one item.
// Every stage has its own valid bit and moves only when the stage after it is
// empty or moving, so a stalled receiver fills the empty stages first and hsl
// ready drops only when all six stages hold an item. Nothing is lost or repeated.
// Reset is asynchronous and clears all valid bits; the block is ready for an
// item in the first cycle after reset is released.
module hsl_to_rgb_pixel (
	input  logic clk,
	input  logic arst_n,
	hsl_in_if.sink hsl,
	hsl_out_if.source rgb
);

	hsl_pkg::norm_t norm_data;
	logic norm_valid;
	logic norm_ready;
	hsl_pkg::light_t light_data;
	logic light_valid;
	logic light_ready;

	hsl_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.hsl      (hsl),
		.dn_data  (norm_data),
		.dn_valid (norm_valid),
		.dn_ready (norm_ready)
	);

	hsl_light u_light (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_data  (norm_data),
		.up_valid (norm_valid),
		.up_ready (norm_ready),
		.dn_data  (light_data),
		.dn_valid (light_valid),
		.dn_ready (light_ready)
	);

	hsl_chan u_chan (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_data  (light_data),
		.up_valid (light_valid),
		.up_ready (light_ready),
		.rgb      (rgb)
	);

endmodule

FILE: rtl/hsl_norm.sv
module hsl_norm (
	input  logic             clk,
	input  logic             arst_n,
	hsl_in_if.sink           hsl,
	output hsl_pkg::norm_t   dn_data,
	output logic             dn_valid,
	input  logic             dn_ready
);

	logic [8:0] hue_c;
	logic [7:0] sat_c;
	logic [7:0] lit_c;
	logic [40:0] s_prod;
	logic [40:0] l_prod;
	logic [16:0] gray_num;
	logic [34:0] gray_prod;
	logic [9:0] red_d;
	logic [8:0] blue_d;
	hsl_pkg::norm_t next;
	hsl_pkg::norm_t data_s1;
	logic valid_s1;
	logic ready_s1;

	always_comb begin
		hue_c = (hsl.hue > hsl_pkg::HUE_MAX) ? hsl_pkg::HUE_MAX : hsl.hue;
		sat_c = (hsl.saturation > hsl_pkg::SCALE_MAX) ? hsl_pkg::SCALE_MAX : hsl.saturation;
		lit_c = (hsl.lightness > hsl_pkg::SCALE_MAX) ? hsl_pkg::SCALE_MAX : hsl.lightness;

		s_prod = {33'd0, sat_c} * {8'd0, hsl_pkg::UNIT_RECIP};
		l_prod = {33'd0, lit_c} * {8'd0, hsl_pkg::UNIT_RECIP};
		gray_num = {9'd0, lit_c} * 17'd510 + 17'd200;
		gray_prod = {18'd0, gray_num} * {17'd0, hsl_pkg::GRAY_RECIP};

		red_d = {1'b0, hue_c} + 10'd120;
		if (red_d > {1'b0, hsl_pkg::HUE_MAX}) begin
			red_d = red_d - {1'b0, hsl_pkg::HUE_MAX};
		end
		if (hue_c < 9'd120) begin
			blue_d = hue_c + 9'd240;
		end else begin
			blue_d = hue_c - 9'd120;
		end

		next.s = s_prod[hsl_pkg::UNIT_SHIFT +: hsl_pkg::UNIT_BITS];
		next.l = l_prod[hsl_pkg::UNIT_SHIFT +: hsl_pkg::UNIT_BITS];
		next.lit_lo = (lit_c < hsl_pkg::LIT_HALF);
		next.sat_zero = (sat_c == 8'd0);
		next.gray = gray_prod[hsl_pkg::GRAY_SHIFT +: 8];
		next.w[hsl_pkg::CH_RED] = hsl_pkg::ramp_weight(red_d[8:0]);
		next.w[hsl_pkg::CH_GREEN] = hsl_pkg::ramp_weight(hue_c);
		next.w[hsl_pkg::CH_BLUE] = hsl_pkg::ramp_weight(blue_d);
	end

	assign ready_s1 = !valid_s1 || dn_ready;
	assign hsl.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= hsl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && hsl.valid) begin
			data_s1 <= next;
		end
	end

	assign dn_data = data_s1;
	assign dn_valid = valid_s1;

endmodule

FILE: rtl/hsl_light.sv
module hsl_light (
	input  logic             clk,
	input  logic             arst_n,
	input  hsl_pkg::norm_t   up_data,
	input  logic             up_valid,
	output logic             up_ready,
	output hsl_pkg::light_t  dn_data,
	output logic             dn_valid,
	input  logic             dn_ready
);

	logic [49:0] sl_prod;
	hsl_pkg::norm_t n_s2;
	hsl_pkg::unit_t ph_s2;
	logic valid_s2;
	logic ready_s2;

	logic [hsl_pkg::UNIT_BITS:0] lo_sum;
	logic [hsl_pkg::UNIT_BITS:0] hi_sum;
	logic [hsl_pkg::UNIT_BITS:0] v2_wide;
	hsl_pkg::unit_t v2_next;
	hsl_pkg::norm_t n_s3;
	hsl_pkg::unit_t v2_s3;
	logic valid_s3;
	logic ready_s3;

	logic [hsl_pkg::UNIT_BITS:0] two_l;
	logic [hsl_pkg::UNIT_BITS:0] v1_wide;
	hsl_pkg::unit_t v1_next;
	hsl_pkg::light_t data_s4;
	logic valid_s4;
	logic ready_s4;

	assign sl_prod = {25'd0, up_data.s} * {25'd0, up_data.l};

	always_comb begin
		lo_sum = {1'b0, n_s2.l} + {1'b0, ph_s2};
		hi_sum = {1'b0, n_s2.l} + {1'b0, n_s2.s} - {1'b0, ph_s2};
		v2_wide = n_s2.lit_lo ? lo_sum : hi_sum;
		if (v2_wide > {1'b0, hsl_pkg::UNIT_ONE}) begin
			v2_next = hsl_pkg::UNIT_ONE;
		end else begin
			v2_next = v2_wide[hsl_pkg::UNIT_BITS-1:0];
		end
	end

	always_comb begin
		two_l = {n_s3.l, 1'b0};
		if (two_l > {1'b0, v2_s3}) begin
			v1_wide = two_l - {1'b0, v2_s3};
		end else begin
			v1_wide = '0;
		end
		if (v1_wide > {1'b0, v2_s3}) begin
			v1_next = v2_s3;
		end else begin
			v1_next = v1_wide[hsl_pkg::UNIT_BITS-1:0];
		end
	end

	assign ready_s4 = !valid_s4 || dn_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign up_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= up_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && up_valid) begin
			n_s2 <= up_data;
			ph_s2 <= sl_prod[hsl_pkg::FRAC_BITS +: hsl_pkg::UNIT_BITS];
		end
		if (ready_s3 && valid_s2) begin
			n_s3 <= n_s2;
			v2_s3 <= v2_next;
		end
		if (ready_s4 && valid_s3) begin
			data_s4.v1 <= v1_next;
			data_s4.span <= v2_s3 - v1_next;
			data_s4.sat_zero <= n_s3.sat_zero;
			data_s4.gray <= n_s3.gray;
			data_s4.w <= n_s3.w;
		end
	end

	assign dn_data = data_s4;
	assign dn_valid = valid_s4;

endmodule

FILE: rtl/hsl_chan.sv
module hsl_chan (
	input  logic             clk,
	input  logic             arst_n,
	input  hsl_pkg::light_t  up_data,
	input  logic             up_valid,
	output logic             up_ready,
	hsl_out_if.source        rgb
);

	hsl_pkg::num_t [hsl_pkg::NUM_CH-1:0] num_next;
	hsl_pkg::num_t [hsl_pkg::NUM_CH-1:0] num_s5;
	logic sat_zero_s5;
	logic [7:0] gray_s5;
	logic valid_s5;
	logic ready_s5;

	logic [34:0] scaled [hsl_pkg::NUM_CH];
	logic [7:0] chan_byte [hsl_pkg::NUM_CH];
	logic [7:0] byte_sel [hsl_pkg::NUM_CH];
	logic black;
	logic [7:0] red_s6;
	logic [7:0] green_s6;
	logic [7:0] blue_s6;
	logic valid_s6;
	logic ready_s6;

	always_comb begin
		for (int c = 0; c < hsl_pkg::NUM_CH; c++) begin
			num_next[c] = {5'd0, up_data.v1} * 30'd60
				+ {5'd0, up_data.span} * {24'd0, up_data.w[c]};
		end
	end

	// 255 * num / (60 * 2^24) rounded half up equals (17 * num + 2^25) >> 26.
	always_comb begin
		for (int c = 0; c < hsl_pkg::NUM_CH; c++) begin
			scaled[c] = {5'd0, num_s5[c]} * 35'd17 + (35'd1 << 25);
			if (scaled[c][34:26] > 9'd255) begin
				chan_byte[c] = 8'd255;
			end else begin
				chan_byte[c] = scaled[c][33:26];
			end
			byte_sel[c] = sat_zero_s5 ? gray_s5 : chan_byte[c];
		end
		black = (byte_sel[hsl_pkg::CH_RED] == 8'd0) && (byte_sel[hsl_pkg::CH_GREEN] == 8'd0)
			&& (byte_sel[hsl_pkg::CH_BLUE] == 8'd0);
	end

	assign ready_s6 = !valid_s6 || rgb.ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign up_ready = ready_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s5) begin
				valid_s5 <= up_valid;
			end
			if (ready_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && up_valid) begin
			num_s5 <= num_next;
			sat_zero_s5 <= up_data.sat_zero;
			gray_s5 <= up_data.gray;
		end
		if (ready_s6 && valid_s5) begin
			red_s6 <= black ? 8'd1 : byte_sel[hsl_pkg::CH_RED];
			green_s6 <= black ? 8'd1 : byte_sel[hsl_pkg::CH_GREEN];
			blue_s6 <= black ? 8'd1 : byte_sel[hsl_pkg::CH_BLUE];
		end
	end

	assign rgb.valid = valid_s6;
	assign rgb.red = red_s6;
	assign rgb.green = green_s6;
	assign rgb.blue = blue_s6;

endmodule

FILE: rtl/hsl_checker.sv
module hsl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("result changed while stalled");

	// Pure black is never produced.
	a_no_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("black result was not raised");

	// The input side backs up only behind a stalled result.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input not ready without output stall");

	// With the receiver always ready the input side never waits.
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready && $past(out_ready) |-> in_ready)
		else $error("input stalled while output was flowing");

	logic unused_in_valid;
	assign unused_in_valid = in_valid;

endmodule

bind hsl_to_rgb_pixel hsl_checker u_hsl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (hsl.valid),
	.in_ready  (hsl.ready),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.red       (rgb.red),
	.green     (rgb.green),
	.blue      (rgb.blue)
);
